// ===== rtl/triangle_column_span_defines.svh =====
// Assertion macros for the triangle column span block.
`ifndef TRIANGLE_COLUMN_SPAN_DEFINES_SVH
`define TRIANGLE_COLUMN_SPAN_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcs assertion failed");
`define TCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcs assertion failed");
`else
`define TCS_ASSERT_IMP(lbl, ante, cons)
`define TCS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
package tcs_pkg;

    localparam int VERT_BITS      = 19;
    localparam int COLOR_BITS     = 24;
    localparam int NUM_REGS       = 7;
    localparam int REG_IDX_BITS   = 3;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int PIXEL_BITS_DEF = 11;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_VERT_A_X   = 3'd0,
        REG_VERT_A_Y   = 3'd1,
        REG_VERT_B_X   = 3'd2,
        REG_VERT_B_Y   = 3'd3,
        REG_VERT_C_X   = 3'd4,
        REG_VERT_C_Y   = 3'd5,
        REG_FILL_COLOR = 3'd6
    } reg_idx_t;

    typedef logic signed [VERT_BITS-1:0] vert_t;

    // one edge ready for interpolation: row = p1 + dy * dx / den
    typedef struct packed {
        logic signed [VERT_BITS-1:0] p1;
        logic        [VERT_BITS-1:0] den;
        logic signed [VERT_BITS:0]   dy;
        logic signed [VERT_BITS:0]   dx;
    } edge_t;

endpackage

// ===== rtl/tcs_ifs.sv =====
`timescale 1ns / 1ps
interface tcs_req_if #(
    parameter int PIXEL_BITS = tcs_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] column_x;

    modport source (output valid, output column_x, input ready);
    modport sink   (input valid, input column_x, output ready);
endinterface

interface tcs_rsp_if #(
    parameter int PIXEL_BITS = tcs_pkg::PIXEL_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [PIXEL_BITS-1:0]      span_bottom;
    logic signed [PIXEL_BITS-1:0]      span_top;
    logic                              covered;
    logic [tcs_pkg::COLOR_BITS-1:0]    pixel_color;

    modport source (output valid, output span_bottom, output span_top, output covered,
                    output pixel_color, input ready);
    modport sink   (input valid, input span_bottom, input span_top, input covered,
                    input pixel_color, output ready);
endinterface

// ===== rtl/triangle_column_span.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// req       in   valid/ready        column_x
// rsp       out  valid/ready        span_bottom, span_top, covered, pixel_color
// cfg       in   cfg_we             cfg_index, cfg_wdata
//
// One word per cycle while rsp is not stalled; the restoring divider yields
// one quotient bit per stage, running for both edges.
// Reset clears valid bits and all configuration registers to zero.
// A stalled rsp freezes the whole pipeline; req.ready follows it.
`include "triangle_column_span_defines.svh"
module triangle_column_span #(
    parameter int FRAC_BITS  = tcs_pkg::FRAC_BITS_DEF,
    parameter int PIXEL_BITS = tcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    tcs_req_if.sink                               req,
    tcs_rsp_if.source                             rsp,
    input  logic                                  cfg_we,
    input  logic [tcs_pkg::REG_IDX_BITS-1:0]      cfg_index,
    input  logic [tcs_pkg::COLOR_BITS-1:0]        cfg_wdata
);
    import tcs_pkg::*;

    localparam int VB  = VERT_BITS;
    localparam int QB  = VB - FRAC_BITS;
    localparam int NW  = 2 * VB + 3;
    localparam int DW  = VB + FRAC_BITS;
    localparam int RW  = QB + 2;
    localparam int SW  = ((RW > PIXEL_BITS) ? RW : PIXEL_BITS) + 1;
    localparam int CW  = ((PIXEL_BITS > VB + 1) ? PIXEL_BITS : VB + 1) + 1;
    localparam int XW  = ((PIXEL_BITS + FRAC_BITS > VB) ? PIXEL_BITS + FRAC_BITS : VB) + 1;
    localparam logic signed [VB:0]   ONE_M1  = (VB+1)'((1 << FRAC_BITS) - 1);
    localparam logic signed [SW-1:0] PIX_MAX = SW'((1 << (PIXEL_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] PIX_MIN = -SW'(1 << (PIXEL_BITS - 1));

    // configuration
    vert_t                 ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [COLOR_BITS-1:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg    <= '0;
            ay_reg    <= '0;
            bx_reg    <= '0;
            by_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VERT_A_X:   ax_reg    <= cfg_wdata[VB-1:0];
                REG_VERT_A_Y:   ay_reg    <= cfg_wdata[VB-1:0];
                REG_VERT_B_X:   bx_reg    <= cfg_wdata[VB-1:0];
                REG_VERT_B_Y:   by_reg    <= cfg_wdata[VB-1:0];
                REG_VERT_C_X:   cx_reg    <= cfg_wdata[VB-1:0];
                REG_VERT_C_Y:   cy_reg    <= cfg_wdata[VB-1:0];
                REG_FILL_COLOR: color_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    logic en;
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    // stage A: input word
    logic                         va_reg;
    logic signed [PIXEL_BITS-1:0] xa_reg;

    // stage B: rotation and edge setup
    function automatic edge_t edge_setup(input vert_t p0, input vert_t p1,
                                         input vert_t q0, input vert_t q1,
                                         input logic signed [XW-1:0] xf,
                                         input logic upper);
        logic signed [VB:0] d;
        logic signed [VB:0] dyr;
        logic signed [XW-1:0] dxw;
        edge_t e;
        d   = (VB+1)'(q0) - (VB+1)'(p0);
        dyr = (VB+1)'(q1) - (VB+1)'(p1);
        dxw = xf - XW'(p0);
        if (d == '0)
        begin
            e.p1  = upper ? ((p1 > q1) ? p1 : q1) : ((p1 < q1) ? p1 : q1);
            e.den = VB'(1);
            e.dy  = '0;
            e.dx  = '0;
        end
        else if (d < 0)
        begin
            e.p1  = p1;
            e.den = VB'(-d);
            e.dy  = -dyr;
            e.dx  = dxw[VB:0];
        end
        else
        begin
            e.p1  = p1;
            e.den = VB'(d);
            e.dy  = dyr;
            e.dx  = dxw[VB:0];
        end
        return e;
    endfunction

    edge_t lo_next, hi_next, lo_reg, hi_reg;
    logic  ins_next, ins_b_reg, vb_reg;

    always_comb
    begin
        vert_t a0, a1, b0, b1, c0, c1, t0, t1, right;
        logic signed [VB:0]    a_ceil, r_floor, c_floor, b_floor;
        logic signed [CW-1:0]  xc;
        logic signed [XW-1:0]  xf;
        logic                  cb, late;
        a0 = ax_reg; a1 = ay_reg; b0 = bx_reg; b1 = by_reg; c0 = cx_reg; c1 = cy_reg;
        t0 = '0;
        t1 = '0;
        for (int k = 0; k < 2; k++)
        begin
            if (a0 > b0 || a0 > c0)
            begin
                t0 = c0; t1 = c1;
                c0 = b0; c1 = b1;
                b0 = a0; b1 = a1;
                a0 = t0; a1 = t1;
            end
        end
        cb      = (c0 <= b0);
        right   = cb ? b0 : c0;
        a_ceil  = ((VB+1)'(a0) + ONE_M1) >>> FRAC_BITS;
        r_floor = (VB+1)'(right) >>> FRAC_BITS;
        c_floor = (VB+1)'(c0) >>> FRAC_BITS;
        b_floor = (VB+1)'(b0) >>> FRAC_BITS;
        xc      = CW'(xa_reg);
        xf      = XW'(xa_reg) <<< FRAC_BITS;
        ins_next = (xc >= CW'(a_ceil)) && (xc <= CW'(r_floor));
        late     = cb ? (xc > CW'(c_floor)) : (xc > CW'(b_floor));
        if (!cb && late)
            lo_next = edge_setup(b0, b1, c0, c1, xf, 1'b0);
        else
            lo_next = edge_setup(a0, a1, b0, b1, xf, 1'b0);
        if (cb && late)
            hi_next = edge_setup(c0, c1, b0, b1, xf, 1'b1);
        else
            hi_next = edge_setup(a0, a1, c0, c1, xf, 1'b1);
    end

    // stage C: products
    logic                        vc_reg, ins_c_reg;
    logic signed [2*VB:0]        plo_reg, phi_reg;
    logic signed [2*VB+1:0]      dlo_reg, dhi_reg;
    logic        [VB-1:0]        denlo_c_reg, denhi_c_reg;

    // stage D and divider stages
    logic                        vd_reg   [QB+1];
    logic                        insd_reg [QB+1];
    logic                        nglo_reg [QB+1];
    logic                        nghi_reg [QB+1];
    logic        [NW-1:0]        rlo_reg  [QB+1];
    logic        [NW-1:0]        rhi_reg  [QB+1];
    logic        [DW-1:0]        dvlo_reg [QB+1];
    logic        [DW-1:0]        dvhi_reg [QB+1];
    logic        [QB-1:0]        qlo_reg  [QB+1];
    logic        [QB-1:0]        qhi_reg  [QB+1];

    logic signed [NW:0] nlo_next, nhi_next;
    always_comb
    begin
        nhi_next = (NW+1)'(phi_reg) + (NW+1)'(dhi_reg);
        nlo_next = -((NW+1)'(plo_reg) + (NW+1)'(dlo_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            va_reg    <= req.valid;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg[0] <= vc_reg;
            for (int k = 1; k <= QB; k++)
                vd_reg[k] <= vd_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg      <= req.column_x;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            ins_b_reg   <= ins_next;
            ins_c_reg   <= ins_b_reg;
            plo_reg     <= lo_reg.p1 * $signed({1'b0, lo_reg.den});
            phi_reg     <= hi_reg.p1 * $signed({1'b0, hi_reg.den});
            dlo_reg     <= lo_reg.dy * lo_reg.dx;
            dhi_reg     <= hi_reg.dy * hi_reg.dx;
            denlo_c_reg <= lo_reg.den;
            denhi_c_reg <= hi_reg.den;
            insd_reg[0] <= ins_c_reg;
            nglo_reg[0] <= nlo_next[NW];
            nghi_reg[0] <= nhi_next[NW];
            rlo_reg[0]  <= nlo_next[NW] ? ~nlo_next[NW-1:0] : nlo_next[NW-1:0];
            rhi_reg[0]  <= nhi_next[NW] ? ~nhi_next[NW-1:0] : nhi_next[NW-1:0];
            dvlo_reg[0] <= DW'(denlo_c_reg) << FRAC_BITS;
            dvhi_reg[0] <= DW'(denhi_c_reg) << FRAC_BITS;
            qlo_reg[0]  <= '0;
            qhi_reg[0]  <= '0;
        end
    end

    for (genvar g = 1; g <= QB; g++)
    begin : g_div
        localparam int BIT = QB - g;
        logic [NW-1:0] slo, shi;
        assign slo = NW'(dvlo_reg[g-1]) << BIT;
        assign shi = NW'(dvhi_reg[g-1]) << BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                insd_reg[g] <= insd_reg[g-1];
                nglo_reg[g] <= nglo_reg[g-1];
                nghi_reg[g] <= nghi_reg[g-1];
                dvlo_reg[g] <= dvlo_reg[g-1];
                dvhi_reg[g] <= dvhi_reg[g-1];
                rlo_reg[g]  <= (rlo_reg[g-1] >= slo) ? rlo_reg[g-1] - slo : rlo_reg[g-1];
                rhi_reg[g]  <= (rhi_reg[g-1] >= shi) ? rhi_reg[g-1] - shi : rhi_reg[g-1];
                qlo_reg[g]  <= qlo_reg[g-1] | (QB'(rlo_reg[g-1] >= slo) << BIT);
                qhi_reg[g]  <= qhi_reg[g-1] | (QB'(rhi_reg[g-1] >= shi) << BIT);
            end
        end
    end

    // final: floor/ceil, coverage, saturation
    logic signed [RW-1:0] qlx, qhx, bot_u, top_u;
    logic signed [SW-1:0] bot_w, top_w;
    logic                 cov_next;
    always_comb
    begin
        qlx      = RW'({1'b0, qlo_reg[QB]});
        qhx      = RW'({1'b0, qhi_reg[QB]});
        bot_u    = nglo_reg[QB] ? qlx + RW'(1) : -qlx;
        top_u    = nghi_reg[QB] ? ~qhx : qhx;
        bot_w    = SW'(bot_u);
        top_w    = SW'(top_u);
        cov_next = insd_reg[QB] && (bot_u <= top_u);
        if (!cov_next)
        begin
            bot_w = '0;
            top_w = '0;
        end
        else
        begin
            bot_w = (bot_w > PIX_MAX) ? PIX_MAX : ((bot_w < PIX_MIN) ? PIX_MIN : bot_w);
            top_w = (top_w > PIX_MAX) ? PIX_MAX : ((top_w < PIX_MIN) ? PIX_MIN : top_w);
        end
    end

    logic                         out_v_reg, out_cov_reg;
    logic signed [PIXEL_BITS-1:0] out_bot_reg, out_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vd_reg[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cov_reg <= cov_next;
            out_bot_reg <= bot_w[PIXEL_BITS-1:0];
            out_top_reg <= top_w[PIXEL_BITS-1:0];
        end
    end

    assign rsp.valid       = out_v_reg;
    assign rsp.span_bottom = out_bot_reg;
    assign rsp.span_top    = out_top_reg;
    assign rsp.covered     = out_cov_reg;
    assign rsp.pixel_color = color_reg;

    `TCS_ASSERT_IMP(a_uncov_zero, out_v_reg && !out_cov_reg, out_bot_reg == '0 && out_top_reg == '0)
    `TCS_ASSERT_IMP(a_cov_order, out_v_reg && out_cov_reg, out_bot_reg <= out_top_reg)
    `TCS_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, va_reg)
    `TCS_ASSERT_NEXT(a_stall_holds_v, rsp.valid && !rsp.ready, rsp.valid && $stable(vd_reg[QB]))

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import tcs_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int PB = PIXEL_BITS_DEF;

    typedef struct {
        logic signed [PB-1:0] bottom;
        logic signed [PB-1:0] top;
        logic                 covered;
        logic [COLOR_BITS-1:0] color;
    } span_t;

    class span_scoreboard;
        vert_t vx[3];
        vert_t vy[3];
        logic [COLOR_BITS-1:0] fill;
        span_t pending[$];
        int errors;

        function new();
            errors = 0;
            fill = '0;
            for (int i = 0; i < 3; i++)
            begin
                vx[i] = '0;
                vy[i] = '0;
            end
        endfunction

        function void set_reg(reg_idx_t idx, logic [COLOR_BITS-1:0] val);
            case (idx)
                REG_VERT_A_X: vx[0] = val[VERT_BITS-1:0];
                REG_VERT_A_Y: vy[0] = val[VERT_BITS-1:0];
                REG_VERT_B_X: vx[1] = val[VERT_BITS-1:0];
                REG_VERT_B_Y: vy[1] = val[VERT_BITS-1:0];
                REG_VERT_C_X: vx[2] = val[VERT_BITS-1:0];
                REG_VERT_C_Y: vy[2] = val[VERT_BITS-1:0];
                REG_FILL_COLOR: fill = val;
                default: ;
            endcase
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            return (n % d != 0 && n < 0) ? q - 1 : q;
        endfunction

        function longint ceil_div(longint n, longint d);
            longint q;
            q = n / d;
            return (n % d != 0 && n > 0) ? q + 1 : q;
        endfunction

        function longint edge_row(longint p0, longint p1, longint q0, longint q1,
                                  longint xf, bit upper);
            longint one;
            longint den;
            longint dy;
            longint t;
            longint y;
            one = longint'(1) << FB;
            den = q0 - p0;
            dy = q1 - p1;
            if (den == 0)
            begin
                if (upper)
                begin
                    y = (p1 > q1) ? p1 : q1;
                    return floor_div(y, one);
                end
                y = (p1 < q1) ? p1 : q1;
                return ceil_div(y, one);
            end
            if (den < 0)
            begin
                den = -den;
                dy = -dy;
            end
            t = p1 * den + dy * (xf - p0);
            return upper ? floor_div(t, den * one) : ceil_div(t, den * one);
        endfunction

        function logic signed [PB-1:0] clamp_row(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (PB - 1)) - 1;
            lo = -(longint'(1) << (PB - 1));
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v[PB-1:0];
        endfunction

        function void note_column(logic signed [PB-1:0] col);
            longint a0, a1, b0, b1, c0, c1, t0, t1;
            longint one, x, xf, bot, top, right;
            bit cov;
            span_t s;
            one = longint'(1) << FB;
            a0 = vx[0]; a1 = vy[0];
            b0 = vx[1]; b1 = vy[1];
            c0 = vx[2]; c1 = vy[2];
            x = col;
            xf = x * one;
            bot = 0;
            top = 0;
            cov = 0;
            for (int k = 0; k < 2; k++)
            begin
                if (a0 > b0 || a0 > c0)
                begin
                    t0 = c0; t1 = c1;
                    c0 = b0; c1 = b1;
                    b0 = a0; b1 = a1;
                    a0 = t0; a1 = t1;
                end
            end
            right = (c0 <= b0) ? b0 : c0;
            if (x >= ceil_div(a0, one) && x <= floor_div(right, one))
            begin
                bot = edge_row(a0, a1, b0, b1, xf, 0);
                top = edge_row(a0, a1, c0, c1, xf, 1);
                if (c0 <= b0)
                begin
                    if (x > floor_div(c0, one))
                        top = edge_row(c0, c1, b0, b1, xf, 1);
                end
                else if (x > floor_div(b0, one))
                    bot = edge_row(b0, b1, c0, c1, xf, 0);
                cov = (bot <= top);
            end
            if (!cov)
            begin
                bot = 0;
                top = 0;
            end
            s.bottom = clamp_row(bot);
            s.top = clamp_row(top);
            s.covered = cov;
            s.color = fill;
            pending.push_back(s);
        endfunction

        function void check_span(span_t got);
            span_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word bottom=%0d top=%0d cov=%0b color=%h",
                         $time, got.bottom, got.top, got.covered, got.color);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.bottom !== exp.bottom)
            begin
                $display("%0t: span_bottom exp %0d got %0d", $time, exp.bottom, got.bottom);
                errors++;
            end
            if (got.top !== exp.top)
            begin
                $display("%0t: span_top exp %0d got %0d", $time, exp.top, got.top);
                errors++;
            end
            if (got.covered !== exp.covered)
            begin
                $display("%0t: covered exp %0b got %0b", $time, exp.covered, got.covered);
                errors++;
            end
            if (got.color !== exp.color)
            begin
                $display("%0t: pixel_color exp %h got %h", $time, exp.color, got.color);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_BITS-1:0] cfg_index;
    logic [COLOR_BITS-1:0] cfg_wdata;
    int send_pct;
    int stall_pct;
    int hold_left;
    span_scoreboard sb;

    tcs_req_if #(.PIXEL_BITS(PB)) req ();
    tcs_rsp_if #(.PIXEL_BITS(PB)) rsp ();

    triangle_column_span #(.FRAC_BITS(FB), .PIXEL_BITS(PB)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("** triangle_column_span: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        span_t got;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                sb.note_column(req.column_x);
            if (rsp.valid && rsp.ready)
            begin
                got.bottom = rsp.span_bottom;
                got.top = rsp.span_top;
                got.covered = rsp.covered;
                got.color = rsp.pixel_color;
                sb.check_span(got);
            end
        end
    end

    // receiver
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp.ready = 0;
                hold_left--;
            end
            else
                rsp.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [COLOR_BITS-1:0] val);
        cfg_we = 1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic load_triangle(vert_t ax, vert_t ay, vert_t bx, vert_t by,
                                 vert_t cx, vert_t cy, logic [COLOR_BITS-1:0] col);
        write_reg(REG_VERT_A_X, {{(COLOR_BITS-VERT_BITS){ax[VERT_BITS-1]}}, ax});
        write_reg(REG_VERT_A_Y, {{(COLOR_BITS-VERT_BITS){ay[VERT_BITS-1]}}, ay});
        write_reg(REG_VERT_B_X, {{(COLOR_BITS-VERT_BITS){bx[VERT_BITS-1]}}, bx});
        write_reg(REG_VERT_B_Y, {{(COLOR_BITS-VERT_BITS){by[VERT_BITS-1]}}, by});
        write_reg(REG_VERT_C_X, {{(COLOR_BITS-VERT_BITS){cx[VERT_BITS-1]}}, cx});
        write_reg(REG_VERT_C_Y, {{(COLOR_BITS-VERT_BITS){cy[VERT_BITS-1]}}, cy});
        write_reg(REG_FILL_COLOR, col);
    endtask

    task automatic send_column(logic signed [PB-1:0] col);
        while ($urandom_range(99) < send_pct)
        begin
            req.valid = 0;
            @(negedge clk);
        end
        req.valid = 1;
        req.column_x = col;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        req.valid = 0;
        n = 0;
        while (sb.pending.size() != 0 && n < 20000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (40) @(negedge clk);
    endtask

    function automatic vert_t rand_coord(int mode);
        case (mode)
            0: return vert_t'($urandom_range(16383) - 8192);
            1: return vert_t'($urandom);
            default: return vert_t'(($urandom_range(63) - 32) * 256);
        endcase
    endfunction

    task automatic random_columns(int n);
        int lo;
        int hi;
        int t;
        lo = sb.vx[0];
        hi = sb.vx[0];
        for (int i = 1; i < 3; i++)
        begin
            t = sb.vx[i];
            if (t < lo) lo = t;
            if (t > hi) hi = t;
        end
        lo = (lo >>> FB) - 3;
        hi = (hi >>> FB) + 3;
        if (lo < -1024) lo = -1024;
        if (hi > 1023) hi = 1023;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send_column(PB'($urandom));
            else
                send_column(PB'(lo + int'($urandom_range(hi - lo))));
        end
    endtask

    initial
    begin
        vert_t v[6];
        int mode;
        sb = new();
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        req.valid = 0;
        req.column_x = '0;
        send_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        rst_n = 0;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // registers at reset: extreme and central columns, degenerate point at origin
        send_column(-1024);
        send_column(1023);
        send_column(0);
        send_column(-1);
        drain();

        // ordinary ccw triangle, one rotation, vertical edges, clockwise
        load_triangle(19'sd256, 19'sd256, 19'sd2560, 19'sd512, 19'sd1280, 19'sd2560, 24'hffffff);
        for (int c = 0; c <= 11; c++) send_column(c);
        drain();
        load_triangle(19'sd1280, 19'sd2560, 19'sd256, 19'sd256, 19'sd2560, 19'sd512, 24'h000000);
        send_column(3); send_column(7);
        drain();
        load_triangle(19'sd512, 19'sd0, 19'sd1536, 19'sd0, 19'sd512, 19'sd1024, 24'h5a5a5a);
        send_column(2); send_column(4); send_column(6);
        drain();
        load_triangle(19'sd256, 19'sd256, 19'sd1280, 19'sd2560, 19'sd2560, 19'sd512, 24'ha5a5a5);
        send_column(5);
        drain();
        // extreme vertices reach the limits of the row range
        load_triangle(vert_t'(-262144), vert_t'(-262144), 19'sd262143, vert_t'(-262144),
                      19'sd0, 19'sd262143, 24'h123456);
        send_column(-1024); send_column(1023); send_column(0);
        drain();

        for (int p = 0; p < 24; p++)
        begin
            mode = p % 4;
            send_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 77 : 35) : 0;
            stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 77 : 35) : 0;
            for (int i = 0; i < 6; i++) v[i] = rand_coord(p % 3);
            if (p % 5 == 2) v[2] = v[0];
            if (p % 7 == 3) v[4] = v[2];
            load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], COLOR_BITS'($urandom));
            if (p == 5)
                hold_left = 300;
            random_columns(62);
            drain();
        end

        if (sb.errors == 0)
            $display("** triangle_column_span: PASSED **");
        else
            $display("** triangle_column_span: FAILED **");
        $finish;
    end
endmodule
